/* hw/rtl/e2rm_pkg.sv */
// ----------------------------------------------------------------------------
// e2rm_pkg: shared types and constants
// CORDIC tables, axis codes and elementary rotation entry selection.
// ----------------------------------------------------------------------------
package e2rm_pkg;

  localparam int FRAC       = 30;          // internal Q30
  localparam int STEPS      = 24;          // CORDIC iterations
  localparam int EW         = 34;          // matrix entry width, Q30 with headroom
  localparam int XW         = 33;          // CORDIC x/y width
  localparam int ZW         = 32;          // CORDIC residual width
  localparam int PHASE_SPLIT = 26;

  localparam logic [63:0] PHASE_SCALE = 64'd716770142402831;
  localparam logic [PHASE_SPLIT-1:0] PHASE_LO = PHASE_SCALE[PHASE_SPLIT-1:0];
  localparam logic [23:0] PHASE_HI = PHASE_SCALE[PHASE_SPLIT+23:PHASE_SPLIT];
  localparam logic signed [XW-1:0] CORDIC_GAIN_INV = 33'sd652032874;

  localparam logic [1:0] REG_FIRST  = 2'd0;
  localparam logic [1:0] REG_SECOND = 2'd1;
  localparam logic [1:0] REG_THIRD  = 2'd2;
  localparam logic [1:0] AXIS_BAD   = 2'd3;

  typedef enum logic [1:0] {
    AXIS_X = 2'd0,
    AXIS_Y = 2'd1,
    AXIS_Z = 2'd2
  } axis_t;

  typedef logic signed [ZW-1:0] atan_tab_t [0:STEPS-1];
  localparam atan_tab_t ATAN_TURNS = '{
    32'sd536870912, 32'sd316933406, 32'sd167458907, 32'sd85004756,
    32'sd42667331,  32'sd21354465,  32'sd10679838,  32'sd5340245,
    32'sd2670163,   32'sd1335087,   32'sd667544,    32'sd333772,
    32'sd166886,    32'sd83443,     32'sd41722,     32'sd20861,
    32'sd10430,     32'sd5215,      32'sd2608,      32'sd1304,
    32'sd652,       32'sd326,       32'sd163,       32'sd81
  };

  // Entry (row, col) of the elementary rotation about ax.
  function automatic logic signed [EW-1:0] elem(axis_t ax, logic signed [EW-1:0] c,
                                                logic signed [EW-1:0] s, int row, int col);
    int k;
    int p;
    int q;
    logic signed [EW-1:0] v;
    unique case (ax)
      AXIS_Y:  k = 1;
      AXIS_Z:  k = 2;
      default: k = 0;
    endcase
    p = (k == 2) ? 0 : k + 1;
    q = (p == 2) ? 0 : p + 1;
    if (row == k && col == k) v = EW'(64'sd1 <<< FRAC);
    else if (row == k || col == k) v = '0;
    else if (row == col) v = c;
    else if (row == q && col == p) v = s;
    else v = -s;
    return v;
  endfunction

endpackage

/* hw/rtl/euler_to_rotation_matrix.sv */
// ----------------------------------------------------------------------------
// euler_to_rotation_matrix: Euler angles to 3x3 rotation matrix
// Pipelined phase scaling, three CORDIC lanes and two 3x3 matrix products.
// ----------------------------------------------------------------------------
// Throughput: one request per cycle; busy is never raised, every stage
//   advances each cycle (the 24 one-step CORDIC stages set the depth).
// Reset: synchronous, clears all valid bits and loads axes Z, Y, X.
// The receiver cannot stall; each result shows for one cycle with done.
module euler_to_rotation_matrix
  import e2rm_pkg::*;
#(
  parameter int ANGLE_WIDTH   = 16,
  parameter int OUT_FRAC_BITS = 14
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  output logic                          busy,
  input  logic signed [ANGLE_WIDTH-1:0] angle_first,
  input  logic signed [ANGLE_WIDTH-1:0] angle_second,
  input  logic signed [ANGLE_WIDTH-1:0] angle_third,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [1:0]                    cfg_index,
  input  logic [1:0]                    cfg_data,
  output logic                          done,
  output logic signed [OUT_FRAC_BITS+1:0] m00,
  output logic signed [OUT_FRAC_BITS+1:0] m01,
  output logic signed [OUT_FRAC_BITS+1:0] m02,
  output logic signed [OUT_FRAC_BITS+1:0] m10,
  output logic signed [OUT_FRAC_BITS+1:0] m11,
  output logic signed [OUT_FRAC_BITS+1:0] m12,
  output logic signed [OUT_FRAC_BITS+1:0] m20,
  output logic signed [OUT_FRAC_BITS+1:0] m21,
  output logic signed [OUT_FRAC_BITS+1:0] m22
);

  localparam int OW  = OUT_FRAC_BITS + 2;
  localparam int PW  = ANGLE_WIDTH + PHASE_SPLIT + 1;   // partial product width
  localparam int SH  = FRAC - OUT_FRAC_BITS;            // final rounding shift
  localparam int RW  = EW + 1;

  // Pipeline never back-pressures; config port always takes writes.
  assign busy      = 1'b0;
  assign cfg_ready = 1'b1;

  // --- axis registers; code 3 and unknown indexes leave them alone ---
  axis_t axis_first, axis_second, axis_third;

  always_ff @(posedge clk) begin
    if (rst) begin
      axis_first  <= AXIS_Z;
      axis_second <= AXIS_Y;
      axis_third  <= AXIS_X;
    end else if (cfg_valid && cfg_data != AXIS_BAD) begin
      unique case (cfg_index)
        REG_FIRST:  axis_first  <= axis_t'(cfg_data);
        REG_SECOND: axis_second <= axis_t'(cfg_data);
        REG_THIRD:  axis_third  <= axis_t'(cfg_data);
        default: ;
      endcase
    end
  end

  // --- stage 1: capture request ---
  logic                          in_v;
  logic signed [ANGLE_WIDTH-1:0] in_ang [0:2];

  always_ff @(posedge clk) begin
    if (rst) in_v <= 1'b0;
    else     in_v <= start;
    in_ang[0] <= angle_first;
    in_ang[1] <= angle_second;
    in_ang[2] <= angle_third;
  end

  // --- stage 2: split product angle * PHASE_SCALE ---
  logic              pp_v;
  logic signed [PW-1:0] pp_lo [0:2];
  logic signed [PW-1:0] pp_hi [0:2];

  always_ff @(posedge clk) begin
    if (rst) pp_v <= 1'b0;
    else     pp_v <= in_v;
    for (int l = 0; l < 3; l++) begin
      pp_lo[l] <= in_ang[l] * $signed({1'b0, PHASE_LO});
      pp_hi[l] <= in_ang[l] * $signed({1'b0, PHASE_HI});
    end
  end

  // --- stage 3: phase in 2^-32 turns, quadrant split, CORDIC seed ---
  logic signed [XW-1:0] cx [0:STEPS][0:2];
  logic signed [XW-1:0] cy [0:STEPS][0:2];
  logic signed [ZW-1:0] cz [0:STEPS][0:2];
  logic [1:0]           cq [0:STEPS][0:2];
  logic                 cv [0:STEPS];
  logic [63:0]          phase_sum [0:2];

  always_comb begin
    for (int l = 0; l < 3; l++) begin
      phase_sum[l] = 64'($signed(pp_lo[l])) + (64'($signed(pp_hi[l])) << PHASE_SPLIT);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) cv[0] <= 1'b0;
    else     cv[0] <= pp_v;
    for (int l = 0; l < 3; l++) begin
      cx[0][l] <= CORDIC_GAIN_INV;
      cy[0][l] <= '0;
      cz[0][l] <= $signed({2'b00, phase_sum[l][61:32]});
      cq[0][l] <= phase_sum[l][63:62];
    end
  end

  // --- stages 4..27: one CORDIC rotation per stage ---
  for (genvar i = 0; i < STEPS; i++) begin : g_cordic
    always_ff @(posedge clk) begin
      if (rst) cv[i+1] <= 1'b0;
      else     cv[i+1] <= cv[i];
      for (int l = 0; l < 3; l++) begin
        if (!cz[i][l][ZW-1]) begin
          cx[i+1][l] <= cx[i][l] - (cy[i][l] >>> i);
          cy[i+1][l] <= cy[i][l] + (cx[i][l] >>> i);
          cz[i+1][l] <= cz[i][l] - ATAN_TURNS[i];
        end else begin
          cx[i+1][l] <= cx[i][l] + (cy[i][l] >>> i);
          cy[i+1][l] <= cy[i][l] - (cx[i][l] >>> i);
          cz[i+1][l] <= cz[i][l] + ATAN_TURNS[i];
        end
        cq[i+1][l] <= cq[i][l];
      end
    end
  end

  // --- stage 28: quadrant unfold and elementary matrices ---
  logic signed [EW-1:0] cos_v [0:2];
  logic signed [EW-1:0] sin_v [0:2];
  logic                 el_v;
  logic signed [EW-1:0] ea [0:2][0:2];
  logic signed [EW-1:0] eb [0:2][0:2];
  logic signed [EW-1:0] ec [0:2][0:2];

  always_comb begin
    for (int l = 0; l < 3; l++) begin
      unique case (cq[STEPS][l])
        2'd0: begin
          cos_v[l] = EW'(cx[STEPS][l]);
          sin_v[l] = EW'(cy[STEPS][l]);
        end
        2'd1: begin
          cos_v[l] = -EW'(cy[STEPS][l]);
          sin_v[l] = EW'(cx[STEPS][l]);
        end
        2'd2: begin
          cos_v[l] = -EW'(cx[STEPS][l]);
          sin_v[l] = -EW'(cy[STEPS][l]);
        end
        default: begin
          cos_v[l] = EW'(cy[STEPS][l]);
          sin_v[l] = -EW'(cx[STEPS][l]);
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) el_v <= 1'b0;
    else     el_v <= cv[STEPS];
    for (int r = 0; r < 3; r++) begin
      for (int c = 0; c < 3; c++) begin
        ea[r][c] <= elem(axis_first,  cos_v[0], sin_v[0], r, c);
        eb[r][c] <= elem(axis_second, cos_v[1], sin_v[1], r, c);
        ec[r][c] <= elem(axis_third,  cos_v[2], sin_v[2], r, c);
      end
    end
  end

  // --- stages 29/30: A = Ra * Rb (products, then sum and round to Q30) ---
  logic                   p1_v, a_v;
  logic signed [2*EW-1:0] p1 [0:2][0:2][0:2];
  logic signed [EW-1:0]   ec1 [0:2][0:2];
  logic signed [2*EW+1:0] s1 [0:2][0:2];
  logic signed [EW-1:0]   am [0:2][0:2];
  logic signed [EW-1:0]   ec2 [0:2][0:2];

  always_ff @(posedge clk) begin
    if (rst) p1_v <= 1'b0;
    else     p1_v <= el_v;
    for (int r = 0; r < 3; r++)
      for (int c = 0; c < 3; c++)
        for (int k = 0; k < 3; k++)
          p1[r][c][k] <= ea[r][k] * eb[k][c];
    ec1 <= ec;
  end

  always_comb begin
    for (int r = 0; r < 3; r++)
      for (int c = 0; c < 3; c++)
        s1[r][c] = (2*EW+2)'(p1[r][c][0]) + (2*EW+2)'(p1[r][c][1])
                 + (2*EW+2)'(p1[r][c][2]) + ((2*EW+2)'(1) <<< (FRAC-1));
  end

  always_ff @(posedge clk) begin
    if (rst) a_v <= 1'b0;
    else     a_v <= p1_v;
    for (int r = 0; r < 3; r++)
      for (int c = 0; c < 3; c++)
        am[r][c] <= s1[r][c][FRAC+EW-1:FRAC];
    ec2 <= ec1;
  end

  // --- stages 31/32: M = A * Rc ---
  logic                   p2_v, mm_v;
  logic signed [2*EW-1:0] p2 [0:2][0:2][0:2];
  logic signed [2*EW+1:0] s2 [0:2][0:2];
  logic signed [EW-1:0]   mm [0:2][0:2];

  always_ff @(posedge clk) begin
    if (rst) p2_v <= 1'b0;
    else     p2_v <= a_v;
    for (int r = 0; r < 3; r++)
      for (int c = 0; c < 3; c++)
        for (int k = 0; k < 3; k++)
          p2[r][c][k] <= am[r][k] * ec2[k][c];
  end

  always_comb begin
    for (int r = 0; r < 3; r++)
      for (int c = 0; c < 3; c++)
        s2[r][c] = (2*EW+2)'(p2[r][c][0]) + (2*EW+2)'(p2[r][c][1])
                 + (2*EW+2)'(p2[r][c][2]) + ((2*EW+2)'(1) <<< (FRAC-1));
  end

  always_ff @(posedge clk) begin
    if (rst) mm_v <= 1'b0;
    else     mm_v <= p2_v;
    for (int r = 0; r < 3; r++)
      for (int c = 0; c < 3; c++)
        mm[r][c] <= s2[r][c][FRAC+EW-1:FRAC];
  end

  // --- stage 33: round to output precision, saturate to +/- one ---
  localparam logic signed [RW-1:0] LIM = RW'(64'sd1 <<< OUT_FRAC_BITS);
  logic signed [RW-1:0] rnd [0:2][0:2];
  logic signed [OW-1:0] mo  [0:2][0:2];

  always_comb begin
    for (int r = 0; r < 3; r++)
      for (int c = 0; c < 3; c++) begin
        if (SH == 0) rnd[r][c] = RW'(mm[r][c]);
        else rnd[r][c] = (RW'(mm[r][c]) + (RW'(1) <<< (SH > 0 ? SH - 1 : 0))) >>> SH;
      end
  end

  always_ff @(posedge clk) begin
    if (rst) done <= 1'b0;
    else     done <= mm_v;
    for (int r = 0; r < 3; r++)
      for (int c = 0; c < 3; c++) begin
        if (rnd[r][c] > LIM)       mo[r][c] <= OW'(LIM);
        else if (rnd[r][c] < -LIM) mo[r][c] <= OW'(-LIM);
        else                       mo[r][c] <= rnd[r][c][OW-1:0];
      end
  end

  assign m00 = mo[0][0];
  assign m01 = mo[0][1];
  assign m02 = mo[0][2];
  assign m10 = mo[1][0];
  assign m11 = mo[1][1];
  assign m12 = mo[1][2];
  assign m20 = mo[2][0];
  assign m21 = mo[2][1];
  assign m22 = mo[2][2];

  // --- checks ---
  a_no_done_after_rst: assert property (@(posedge clk) rst |=> !done)
    else $error("done right after reset");

  a_bad_code_ignored: assert property (@(posedge clk) disable iff (rst)
    (cfg_valid && cfg_data == AXIS_BAD)
      |=> ($stable(axis_first) && $stable(axis_second) && $stable(axis_third)))
    else $error("axis code 3 changed a register");

  a_diag_saturated: assert property (@(posedge clk) disable iff (rst)
    done |-> (RW'(m00) <= LIM && RW'(m00) >= -LIM && RW'(m11) <= LIM && RW'(m11) >= -LIM))
    else $error("matrix entry outside saturation range");

  a_valid_chain: assert property (@(posedge clk) disable iff (rst)
    mm_v |=> done)
    else $error("result lost in output stage");

endmodule

/* dv/tb_euler_to_rotation_matrix.sv */
// ----------------------------------------------------------------------------
// tb_euler_to_rotation_matrix: self-checking bench for the Euler converter
// A directed table and then random angle triples are run under several axis
// orders. A fixed-point CORDIC and matrix-product predictor computes each matrix
// not typed in the table, and every done strobe is checked against the oldest expected one.
// ----------------------------------------------------------------------------
module tb_euler_to_rotation_matrix
  import e2rm_pkg::*;
;

  typedef logic signed [15:0] ang_t;
  typedef logic signed [15:0] ent_t;
  typedef ent_t [0:8] mat_t;          // row-major, index 0 = m00
  typedef longint rot_t [3][3];        // Q30 working matrix

  typedef struct {
    ang_t a1, a2, a3;
    bit   typed;                       // expected matrix typed in below
    mat_t m;
  } row_t;

  localparam int LATENCY = 33;
  localparam ent_t ONE_Q14 = 16'sd16384;
  localparam mat_t IDENT = '{ONE_Q14, 16'sd0, 16'sd0,
                             16'sd0, ONE_Q14, 16'sd0,
                             16'sd0, 16'sd0, ONE_Q14};

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic start = 1'b0;
  logic busy;
  ang_t angle_first = '0, angle_second = '0, angle_third = '0;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [1:0] cfg_index = '0, cfg_data = '0;
  logic done;
  ent_t m00, m01, m02, m10, m11, m12, m20, m21, m22;

  // typed expectation travels with the request it belongs to
  bit   req_typed = 1'b0;
  mat_t req_typed_m = '0;

  axis_t axis_order [3];
  mat_t  pending_mats [$];
  int    mismatch_cnt = 0;
  int    idle_pct = 0;

  euler_to_rotation_matrix dut (
    .clk, .rst, .start, .busy,
    .angle_first, .angle_second, .angle_third,
    .cfg_valid, .cfg_ready, .cfg_index, .cfg_data,
    .done, .m00, .m01, .m02, .m10, .m11, .m12, .m20, .m21, .m22
  );

  always #5 clk = ~clk;

  // ---------------------------------------------------------------- predictor
  // Angle -> phase in 2^-32 turns, quadrant fold, 24-step CORDIC in Q30.
  function automatic void cordic_sin_cos(input ang_t ang, output longint c, output longint s);
    longint a, x, y, z, nx, ny;
    logic [63:0] prod;
    logic [31:0] ph;
    a = ang;
    prod = a * PHASE_SCALE;            // wraps at 64 bits: whole turns drop out
    ph = prod[63:32];
    z = longint'({34'b0, ph[29:0]});
    x = CORDIC_GAIN_INV;
    y = 0;
    for (int i = 0; i < STEPS; i++) begin
      if (z >= 0) begin
        nx = x - (y >>> i);
        ny = y + (x >>> i);
        z = z - ATAN_TURNS[i];
      end else begin
        nx = x + (y >>> i);
        ny = y - (x >>> i);
        z = z + ATAN_TURNS[i];
      end
      x = nx;
      y = ny;
    end
    case (ph[31:30])
      2'd0:    begin c = x;  s = y;  end
      2'd1:    begin c = -y; s = x;  end
      2'd2:    begin c = -x; s = -y; end
      default: begin c = y;  s = -x; end
    endcase
  endfunction

  function automatic void axis_rotation(input axis_t ax, input ang_t ang, output rot_t r);
    longint c, s;
    int k, p, q;
    cordic_sin_cos(ang, c, s);
    k = int'(ax);
    p = (k + 1) % 3;
    q = (k + 2) % 3;
    foreach (r[i, j]) r[i][j] = 0;
    r[k][k] = longint'(1) << FRAC;
    r[p][p] = c;
    r[q][q] = c;
    r[q][p] = s;
    r[p][q] = -s;
  endfunction

  // Q30 product, each entry rounded half up back to Q30
  function automatic void q30_matmul(input rot_t a, input rot_t b, output rot_t res);
    longint acc;
    for (int i = 0; i < 3; i++)
      for (int j = 0; j < 3; j++) begin
        acc = 0;
        for (int k = 0; k < 3; k++) acc += a[i][k] * b[k][j];
        res[i][j] = (acc + (longint'(1) << (FRAC - 1))) >>> FRAC;
      end
  endfunction

  function automatic mat_t rotation_matrix(ang_t a1, ang_t a2, ang_t a3);
    rot_t ra, rb, rc, t, m;
    longint v;
    mat_t out;
    axis_rotation(axis_order[0], a1, ra);
    axis_rotation(axis_order[1], a2, rb);
    axis_rotation(axis_order[2], a3, rc);
    q30_matmul(ra, rb, t);
    q30_matmul(t, rc, m);
    for (int i = 0; i < 3; i++)
      for (int j = 0; j < 3; j++) begin
        v = (m[i][j] + (longint'(1) << 15)) >>> 16;  // Q30 -> Q14, half up
        if (v > 16384) v = 16384;
        if (v < -16384) v = -16384;
        out[i * 3 + j] = v[15:0];
      end
    return out;
  endfunction

  // ------------------------------------------------------------------ monitor
  // Registers and requests are both taken on the edge the DUT sees them.
  always @(posedge clk) begin
    mat_t got, want;
    if (rst) begin
      axis_order = '{AXIS_Z, AXIS_Y, AXIS_X};
    end else begin
      if (cfg_valid && cfg_ready && cfg_index <= REG_THIRD && cfg_data != AXIS_BAD)
        axis_order[cfg_index] = axis_t'(cfg_data);
      if (start && !busy)
        pending_mats.push_back(req_typed ? req_typed_m :
                               rotation_matrix(angle_first, angle_second, angle_third));
      if (done) begin
        got = '{m00, m01, m02, m10, m11, m12, m20, m21, m22};
        if (pending_mats.size() == 0) begin
          mismatch_cnt++;
          if (mismatch_cnt <= 10) $display("unexpected result at %0t", $time);
        end else begin
          want = pending_mats.pop_front();
          for (int f = 0; f < 9; f++)
            if (got[f] !== want[f]) begin
              mismatch_cnt++;
              if (mismatch_cnt <= 10)
                $display("m%0d%0d: expected %0d got %0d at %0t",
                         f / 3, f % 3, want[f], got[f], $time);
            end
        end
      end
    end
  end

  // ------------------------------------------------------------------ drivers
  // All inputs move on the falling edge.
  task automatic write_reg(logic [1:0] idx, logic [1:0] val);
    @(negedge clk);
    cfg_valid = 1'b1;
    cfg_index = idx;
    cfg_data  = val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  task automatic set_axes(axis_t f, axis_t s, axis_t t);
    write_reg(REG_FIRST, f);
    write_reg(REG_SECOND, s);
    write_reg(REG_THIRD, t);
  endtask

  // One request; random idle cycles in front of it.
  task automatic send_angles(ang_t a1, ang_t a2, ang_t a3, bit typed, mat_t m);
    @(negedge clk);
    while ($urandom_range(99) < idle_pct) begin
      start = 1'b0;
      @(negedge clk);
    end
    start = 1'b1;
    angle_first = a1;
    angle_second = a2;
    angle_third = a3;
    req_typed = typed;
    req_typed_m = m;
    @(posedge clk);
    while (busy) @(posedge clk);
  endtask

  task automatic drain;
    @(negedge clk);
    start = 1'b0;
    req_typed = 1'b0;
    while (pending_mats.size() != 0) @(posedge clk);
  endtask

  function automatic ang_t rand_angle();
    // mostly within a few turns, sometimes anywhere in the field
    if ($urandom_range(3) == 0) return ang_t'($urandom);
    return ang_t'($urandom_range(60000) - 30000);
  endfunction

  // Directed rows: zero angles give the identity under any axis order.
  row_t dir_rows [] = '{
    '{16'sd0,      16'sd0,      16'sd0,      1'b1, IDENT},
    '{16'sd32767,  16'sd32767,  16'sd32767,  1'b0, '0},
    '{-16'sd32768, -16'sd32768, -16'sd32768, 1'b0, '0},
    '{16'sd6434,   16'sd0,      16'sd0,      1'b0, '0},   // about +pi/2
    '{16'sd0,      -16'sd6434,  16'sd0,      1'b0, '0},
    '{16'sd0,      16'sd0,      16'sd12868,  1'b0, '0},   // about pi
    '{16'sd3217,   16'sd3217,   16'sd3217,   1'b0, '0},
    '{16'sd25736,  -16'sd25736, 16'sd19302,  1'b0, '0},   // whole turns, then three quarters of a turn
    '{16'sh5555,   16'shAAAA,   16'sh5555,   1'b0, '0},
    '{16'shAAAA,   16'sh5555,   16'shAAAA,   1'b0, '0},
    '{16'sd1,      -16'sd1,     16'sd1,      1'b0, '0},
    '{-16'sd1,     16'sd1,      -16'sd1,     1'b0, '0}
  };

  // ---------------------------------------------------------------- sequence
  initial begin
    axis_t ax [3];
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // reset order Z,Y,X, then the directed table
    foreach (dir_rows[r])
      send_angles(dir_rows[r].a1, dir_rows[r].a2, dir_rows[r].a3,
                  dir_rows[r].typed, dir_rows[r].m);
    drain();

    // repeated axes; a bad axis code and an out-of-range index are ignored
    set_axes(AXIS_X, AXIS_X, AXIS_Z);
    write_reg(REG_FIRST, AXIS_BAD);
    write_reg(2'd3, AXIS_Y);
    send_angles(16'sd0, 16'sd0, 16'sd0, 1'b1, IDENT);
    foreach (dir_rows[r])
      send_angles(dir_rows[r].a1, dir_rows[r].a2, dir_rows[r].a3, 1'b0, '0);
    drain();

    // random part: 6 segments, each with its axis order set anew; the idle rate changes every two
    for (int seg = 0; seg < 6; seg++) begin
      idle_pct = (seg < 2) ? 12 : (seg < 4) ? 61 : 0;
      case (seg)
        0:       set_axes(AXIS_X, AXIS_X, AXIS_X);
        1:       set_axes(AXIS_Z, AXIS_Z, AXIS_Z);
        2:       set_axes(AXIS_X, AXIS_Y, AXIS_Z);
        default: begin
          foreach (ax[k]) ax[k] = axis_t'($urandom_range(2));
          set_axes(ax[0], ax[1], ax[2]);
        end
      endcase
      repeat (67) send_angles(rand_angle(), rand_angle(), rand_angle(), 1'b0, '0);
      drain();
    end

    repeat (LATENCY + 10) @(posedge clk);
    if (mismatch_cnt == 0) $display("SCOREBOARD CLEAN");
    else $display("SCOREBOARD MISMATCH");
    $finish;
  end

  // watchdog
  initial begin
    #2000000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule
